// ----- rtl/perspective_pixel_projector_macros.svh -----
// Assertion macros shared by the projector RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef PERSPECTIVE_PIXEL_PROJECTOR_MACROS_SVH
`define PERSPECTIVE_PIXEL_PROJECTOR_MACROS_SVH

// Checked at every rising edge outside reset.
`define PPP_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define PPP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ppp_pkg.sv -----
// Types and constants of the perspective pixel projector.
// No dependencies; used by every other file of the block but the macro header.
package ppp_pkg;

  localparam int COEF_W   = 32;
  localparam int POS_W    = 32;
  localparam int SIZE_W   = 11;
  localparam int NEAR_W   = 31;
  localparam int PIX_W    = 20;
  localparam int DEPTH_W  = 32;
  localparam int IDX_W    = 4;
  localparam int NCOEF    = 16;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;
  localparam int QCNT_W   = 3;
  localparam int ADDR_W   = 4;
  localparam int PDATA_W  = 32;

  // Homogeneous coordinate 1.0 in Q16.16.
  localparam logic signed [POS_W-1:0] W_ONE = 32'sh0001_0000;

  typedef enum logic {
    KIND_COEF  = 1'b0,
    KIND_POINT = 1'b1
  } kind_t;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_NEAR   = 2'd2;

  typedef struct packed {
    kind_t                    kind;
    logic [IDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
  } q_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0] width_pixels;
    logic [SIZE_W-1:0] height_pixels;
    logic [NEAR_W-1:0] near_limit;
  } cfg_t;

endpackage

// ----- rtl/ppp_if.sv -----
// Valid/ready channel interfaces for input items and result items.
// Depends on ppp_pkg.
interface ppp_item_if import ppp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  kind_t                    kind;
  logic [IDX_W-1:0]         coef_index;
  logic signed [COEF_W-1:0] coef_value;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;

  modport source (output valid, kind, coef_index, coef_value, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, kind, coef_index, coef_value, pos_x, pos_y, pos_z,
                output ready);
endinterface

interface ppp_result_if import ppp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic [PIX_W-1:0]          pixel_index;
  logic signed [DEPTH_W-1:0] depth;

  modport source (output valid, hit, pixel_index, depth, input ready);
  modport sink (input valid, hit, pixel_index, depth, output ready);
endinterface

// ----- rtl/ppp_cfg.sv -----
// APB-style register port: viewport width, height and near limit.
// Depends on ppp_pkg.
module ppp_cfg import ppp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width_pixels  <= SIZE_W'(1);
      cfg.height_pixels <= SIZE_W'(1);
      cfg.near_limit    <= '0;
    end else if (wr) begin
      case (paddr[ADDR_W-1:2])
        REG_WIDTH:  cfg.width_pixels  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: cfg.height_pixels <= pwdata[SIZE_W-1:0];
        REG_NEAR:   cfg.near_limit    <= pwdata[NEAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_WIDTH:  prdata = PDATA_W'(cfg.width_pixels);
      REG_HEIGHT: prdata = PDATA_W'(cfg.height_pixels);
      REG_NEAR:   prdata = PDATA_W'(cfg.near_limit);
      default:    prdata = '0;
    endcase
  end

endmodule

// ----- rtl/ppp_front.sv -----
// Front end: accepts items and queues them, coefficient writes and points alike,
// so the back end sees them in order. Depends on ppp_pkg, ppp_if and the macro header.
`include "perspective_pixel_projector_macros.svh"
module ppp_front import ppp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ppp_item_if.sink     item,
  output q_item_t      q,
  output logic         q_valid,
  input  logic         q_pop
);

  q_item_t           fifo [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] cnt;
  logic [QCNT_W-1:0] cnt_inc;
  logic              push;

  assign item.ready = (cnt != QCNT_W'(QDEPTH));
  assign push       = item.valid && item.ready;
  assign q_valid    = (cnt != '0);
  assign q          = fifo[rd_ptr];
  assign cnt_inc    = cnt + QCNT_W'(1);

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= '{kind: item.kind, coef_index: item.coef_index,
                        coef_value: item.coef_value, pos_x: item.pos_x,
                        pos_y: item.pos_y, pos_z: item.pos_z};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (q_pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, q_pop})
        2'b10:   cnt <= cnt_inc;
        2'b01:   cnt <= cnt - QCNT_W'(1);
        default: cnt <= cnt;
      endcase
    end
  end

  `PPP_ASSERT(a_cnt_bound, clk, rst, cnt <= QCNT_W'(QDEPTH), "queue count over depth")
  `PPP_ASSERT(a_push_count, clk, rst, (push && !q_pop) |=> cnt == $past(cnt_inc), "push lost")
  `PPP_ASSERT(a_pop_nonempty, clk, rst, q_pop |-> q_valid, "pop from empty queue")

endmodule

// ----- rtl/ppp_back.sv -----
// Back end: coefficient store, 4x4 transform, restoring division and viewport test.
// Depends on ppp_pkg, ppp_if and the assertion macro header.
`include "perspective_pixel_projector_macros.svh"
module ppp_back import ppp_pkg::*; #(
  parameter int MAX_SIDE       = 1024,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  q_item_t     q,
  input  logic        q_valid,
  output logic        q_pop,
  input  cfg_t        cfg,
  ppp_result_if.source result
);

  localparam int QB   = $clog2(MAX_SIDE + 1);
  localparam int PW   = 2 * COEF_W;
  localparam int SW   = PW + 2 - COEF_FRAC_BITS;
  localparam int DW   = SW + QB;
  localparam int LW   = 2 * QB + 1;
  localparam int LAST = 4 + QB;

  logic              adv;
  logic [LAST:0]     vld;
  logic signed [COEF_W-1:0] coef [NCOEF];
  logic signed [POS_W-1:0]  vec [4];
  logic signed [PW-1:0]     prod [NCOEF];
  logic signed [SW-1:0]     row_sum [4];
  logic signed [SW-1:0]     xp, yp, zp, wp;
  // Stage two: magnitudes and flags.
  logic [SW-1:0]            ax2, ay2, b2;
  logic                     negx2, negy2, wnz2, near2;
  logic [DEPTH_W-1:0]       dep2;
  // Division stages; entry 0 is the range-check stage.
  logic [SW-1:0]            rx [QB+1];
  logic [SW-1:0]            ry [QB+1];
  logic [QB-1:0]            qx [QB+1];
  logic [QB-1:0]            qy [QB+1];
  logic [SW-1:0]            bd [QB+1];
  logic                     ok [QB+1];
  logic                     negx [QB+1];
  logic                     negy [QB+1];
  logic [DEPTH_W-1:0]       dep [QB+1];
  logic [QB-1:0]            wc, hc;
  logic                     hit_c;
  logic [LW-1:0]            lin;
  logic                     zfits;
  logic                     res_hit;
  logic [PIX_W-1:0]         res_pix;
  logic [DEPTH_W-1:0]       res_dep;
  logic                     miss_clean;
  logic                     hit_far;

  assign adv   = !vld[LAST] || result.ready;
  assign q_pop = adv && q_valid;

  assign vec[0] = q.pos_x;
  assign vec[1] = q.pos_y;
  assign vec[2] = q.pos_z;
  assign vec[3] = W_ONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], q_pop && (q.kind == KIND_POINT)};
    end
  end

  // Coefficient writes take effect in queue order with the points.
  always_ff @(posedge clk) begin
    if (q_pop && (q.kind == KIND_COEF)) begin
      coef[q.coef_index] <= q.coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NCOEF; k++) begin
        prod[k] <= PW'(coef[k]) * PW'(vec[k % 4]);
      end
    end
  end

  // Arithmetic shift right is the floor of the scaled product.
  always_comb begin
    logic signed [PW-1:0] sh;
    for (int r = 0; r < 4; r++) begin
      row_sum[r] = '0;
      for (int c = 0; c < 4; c++) begin
        sh = prod[4*r+c] >>> COEF_FRAC_BITS;
        row_sum[r] = row_sum[r] + $signed(sh[SW-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xp <= row_sum[0];
      yp <= row_sum[1];
      zp <= row_sum[2];
      wp <= row_sum[3];
    end
  end

  assign zfits = (zp[SW-1:DEPTH_W-1] == '0) || (zp[SW-1:DEPTH_W-1] == '1);

  always_ff @(posedge clk) begin
    if (adv) begin
      ax2   <= xp[SW-1] ? SW'(-xp) : SW'(xp);
      ay2   <= yp[SW-1] ? SW'(-yp) : SW'(yp);
      b2    <= wp[SW-1] ? SW'(-wp) : SW'(wp);
      negx2 <= xp[SW-1] ^ wp[SW-1];
      negy2 <= yp[SW-1] ^ wp[SW-1];
      wnz2  <= (wp != '0);
      near2 <= zp > $signed(SW'(cfg.near_limit));
      if (zfits) dep2 <= zp[DEPTH_W-1:0];
      else if (zp[SW-1]) dep2 <= {1'b1, {(DEPTH_W-1){1'b0}}};
      else dep2 <= {1'b0, {(DEPTH_W-1){1'b1}}};
    end
  end

  // Quotients below 2^QB are the only ones that can land in the viewport.
  always_ff @(posedge clk) begin
    if (adv) begin
      rx[0]   <= ax2;
      ry[0]   <= ay2;
      qx[0]   <= '0;
      qy[0]   <= '0;
      bd[0]   <= b2;
      ok[0]   <= wnz2 && near2 && ({QB'(0), ax2} < {b2, QB'(0)})
                 && ({QB'(0), ay2} < {b2, QB'(0)});
      negx[0] <= negx2;
      negy[0] <= negy2;
      dep[0]  <= dep2;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_div
    localparam int K = QB - 1 - s;
    logic [DW-1:0] trial;
    logic          gex, gey;

    assign trial = DW'(bd[s]) << K;
    assign gex   = DW'(rx[s]) >= trial;
    assign gey   = DW'(ry[s]) >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        rx[s+1]   <= gex ? SW'(DW'(rx[s]) - trial) : rx[s];
        ry[s+1]   <= gey ? SW'(DW'(ry[s]) - trial) : ry[s];
        qx[s+1]   <= qx[s] | (QB'(gex) << K);
        qy[s+1]   <= qy[s] | (QB'(gey) << K);
        bd[s+1]   <= bd[s];
        ok[s+1]   <= ok[s];
        negx[s+1] <= negx[s];
        negy[s+1] <= negy[s];
        dep[s+1]  <= dep[s];
      end
    end
  end

  assign wc = (32'(cfg.width_pixels) > MAX_SIDE) ? QB'(MAX_SIDE) : QB'(cfg.width_pixels);
  assign hc = (32'(cfg.height_pixels) > MAX_SIDE) ? QB'(MAX_SIDE) : QB'(cfg.height_pixels);

  // A negative truncated quotient is only in view when it is zero.
  assign hit_c = ok[QB] && ((qx[QB] == '0) || !negx[QB]) && ((qy[QB] == '0) || !negy[QB])
                 && (qx[QB] < wc) && (qy[QB] < hc);
  assign lin   = LW'(qx[QB]) + LW'(wc) * LW'(qy[QB]);

  always_ff @(posedge clk) begin
    if (adv) begin
      res_hit <= hit_c;
      res_pix <= hit_c ? PIX_W'(lin) : '0;
      res_dep <= dep[QB];
    end
  end

  assign result.valid       = vld[LAST];
  assign result.hit         = res_hit;
  assign result.pixel_index = res_pix;
  assign result.depth       = res_dep;

  assign miss_clean = result.hit || (result.pixel_index == '0);
  assign hit_far    = !result.depth[DEPTH_W-1]
                      && (result.depth[NEAR_W-1:0] >= cfg.near_limit);

  `PPP_ASSERT(a_stall_hold, clk, rst, !adv |=> $stable(vld), "pipeline moved while stalled")
  `PPP_ASSERT(a_miss_zero, clk, rst, result.valid |-> miss_clean, "miss with nonzero index")
  `PPP_ASSERT(a_hit_depth, clk, rst, (result.valid && result.hit) |-> hit_far, "hit before near")

endmodule

// ----- rtl/perspective_pixel_projector.sv -----
// Perspective pixel projector: 4x4 homogeneous transform of a point, divide by w,
// viewport test and linear pixel index. One item is accepted every cycle while the
// result side keeps up. A projection passes through the product, row-sum, magnitude
// and range-check registers, then the restoring divider, one quotient bit per stage
// (QB = 11 quotient bits at MAX_SIDE = 1024), then the result register. A four-entry
// queue separates the input side from the arithmetic pipeline. Coefficient writes
// pass through the same queue and produce no result; coefficients must be written
// before they are used. Depends on ppp_pkg, ppp_if, ppp_cfg, ppp_front and ppp_back.
module perspective_pixel_projector import ppp_pkg::*; #(
  parameter int MAX_SIDE       = 1024,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  ppp_item_if.sink           item,
  ppp_result_if.source       result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t    cfg;
  q_item_t q;
  logic    q_valid;
  logic    q_pop;

  ppp_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  ppp_front u_front (
    .clk, .rst, .item, .q, .q_valid, .q_pop
  );

  ppp_back #(
    .MAX_SIDE(MAX_SIDE),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_back (
    .clk, .rst, .q, .q_valid, .q_pop, .cfg, .result
  );

endmodule
